// ===== hdl/xeu_pkg.sv =====
// ----------------------------------------------------------------------------
// xeu_pkg: shared types, constants and trie tables of the entity decoder
// Holds the prefix trie of the five predefined XML entities, the bytes held
// at each trie node and the character each complete entity stands for.
// ----------------------------------------------------------------------------
package xeu_pkg;

  // Longest burst of output bytes one input byte can cause: a held "&quot"
  // or "&apos" followed by a byte that does not fit.
  localparam int unsigned OUT_DEPTH = 6;
  localparam int unsigned CNT_W     = $clog2(OUT_DEPTH + 1);

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [3:0] {
    ND_IDLE = 4'd0,
    ND_AMP  = 4'd1,
    ND_L    = 4'd2,
    ND_LT   = 4'd3,
    ND_G    = 4'd4,
    ND_GT   = 4'd5,
    ND_Q    = 4'd6,
    ND_QU   = 4'd7,
    ND_QUO  = 4'd8,
    ND_QUOT = 4'd9,
    ND_A    = 4'd10,
    ND_AP   = 4'd11,
    ND_APO  = 4'd12,
    ND_APOS = 4'd13,
    ND_AM   = 4'd14,
    ND_AMPR = 4'd15
  } node_t;

  typedef struct packed {
    logic  hit;
    node_t next;
  } step_t;

  // One edge of the trie, taken when the byte extends the held prefix.
  function automatic step_t trie_step(input node_t node, input logic [7:0] b);
    step_t s;
    s.hit  = 1'b0;
    s.next = ND_IDLE;
    case (node)
      ND_IDLE: if (b == "&") s = '{1'b1, ND_AMP};
      ND_AMP: begin
        case (b)
          "l":     s = '{1'b1, ND_L};
          "g":     s = '{1'b1, ND_G};
          "q":     s = '{1'b1, ND_Q};
          "a":     s = '{1'b1, ND_A};
          default: s = '{1'b0, ND_IDLE};
        endcase
      end
      ND_L:   if (b == "t") s = '{1'b1, ND_LT};
      ND_G:   if (b == "t") s = '{1'b1, ND_GT};
      ND_Q:   if (b == "u") s = '{1'b1, ND_QU};
      ND_QU:  if (b == "o") s = '{1'b1, ND_QUO};
      ND_QUO: if (b == "t") s = '{1'b1, ND_QUOT};
      ND_A: begin
        if (b == "p") s = '{1'b1, ND_AP};
        else if (b == "m") s = '{1'b1, ND_AM};
      end
      ND_AP:  if (b == "o") s = '{1'b1, ND_APO};
      ND_APO: if (b == "s") s = '{1'b1, ND_APOS};
      ND_AM:  if (b == "p") s = '{1'b1, ND_AMPR};
      default: s = '{1'b0, ND_IDLE};
    endcase
    return s;
  endfunction

  // Bytes held at a node, first byte in the lowest bits.
  function automatic logic [8*OUT_DEPTH-1:0] held_text(input node_t node);
    logic [8*OUT_DEPTH-1:0] t;
    t = '0;
    case (node)
      ND_IDLE: t = '0;
      ND_AMP:  t[7:0]  = "&";
      ND_L:    t[15:0] = {"l", "&"};
      ND_LT:   t[23:0] = {"t", "l", "&"};
      ND_G:    t[15:0] = {"g", "&"};
      ND_GT:   t[23:0] = {"t", "g", "&"};
      ND_Q:    t[15:0] = {"q", "&"};
      ND_QU:   t[23:0] = {"u", "q", "&"};
      ND_QUO:  t[31:0] = {"o", "u", "q", "&"};
      ND_QUOT: t[39:0] = {"t", "o", "u", "q", "&"};
      ND_A:    t[15:0] = {"a", "&"};
      ND_AP:   t[23:0] = {"p", "a", "&"};
      ND_APO:  t[31:0] = {"o", "p", "a", "&"};
      ND_APOS: t[39:0] = {"s", "o", "p", "a", "&"};
      ND_AM:   t[23:0] = {"m", "a", "&"};
      ND_AMPR: t[31:0] = {"p", "m", "a", "&"};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic cnt_t held_len(input node_t node);
    cnt_t n;
    case (node)
      ND_IDLE:                       n = cnt_t'(0);
      ND_AMP:                        n = cnt_t'(1);
      ND_L, ND_G, ND_Q, ND_A:        n = cnt_t'(2);
      ND_LT, ND_GT, ND_QU, ND_AP,
      ND_AM:                         n = cnt_t'(3);
      ND_QUO, ND_APO, ND_AMPR:       n = cnt_t'(4);
      ND_QUOT, ND_APOS:              n = cnt_t'(5);
      default:                       n = cnt_t'(0);
    endcase
    return n;
  endfunction

  // Character a node stands for when a ';' follows it; zero if incomplete.
  function automatic logic [7:0] entity_char(input node_t node);
    logic [7:0] c;
    case (node)
      ND_LT:   c = "<";
      ND_GT:   c = ">";
      ND_QUOT: c = "\"";
      ND_APOS: c = "'";
      ND_AMPR: c = "&";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/xml_entity_unescape_unit.sv =====
// ----------------------------------------------------------------------------
// xml_entity_unescape_unit: streaming decoder of predefined XML entities
// Replaces &lt; &gt; &quot; &apos; &amp; by their characters, one escaped
// byte in per word, passing any other byte sequence through unchanged.
// ----------------------------------------------------------------------------
//  Channel | Direction | tdata            | tlast
//  in_     | slave     | [7:0] text_byte  | end_of_string
//  out_    | master    | [7:0] plain_byte | last_byte
//
//  An input word is decoded in the cycle it is accepted and its output bytes
//  (none to six) are loaded into a six-byte shift buffer, shown from the
//  next cycle. The buffer drains one byte a cycle while out_tready is high.
//  A new word is taken in the cycle the last buffered byte leaves, so words
//  causing at most one byte flow at one per cycle while out_tready is high.
//  Reset clears the trie node and empties the buffer.
module xml_entity_unescape_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] plain_byte
  output logic       out_tlast
);
  import xeu_pkg::*;

  node_t      node_r, node_nxt;
  cnt_t       cnt_r, cnt_nxt;
  logic       last_r, last_nxt;
  logic [7:0] buf_r   [OUT_DEPTH];
  logic [7:0] buf_nxt [OUT_DEPTH];

  logic       in_fire, out_fire;
  step_t      step;
  logic [7:0] ent;
  node_t      emit_node;
  cnt_t       emit_len;
  cnt_t       emit_cnt;
  logic       emit_tail;
  logic [8*OUT_DEPTH-1:0] held;
  logic [7:0] lst [OUT_DEPTH];

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = buf_r[0];
  assign out_tlast  = last_r && (cnt_r == cnt_t'(1));
  assign in_tready  = (cnt_r == '0) || ((cnt_r == cnt_t'(1)) && out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign out_fire   = out_tvalid && out_tready;

  // Decode one byte against the held prefix.
  always_comb begin
    step      = trie_step(node_r, in_tdata);
    ent       = entity_char(node_r);
    node_nxt  = node_r;
    emit_node = node_r;
    emit_tail = 1'b0;
    emit_cnt  = '0;
    if ((ent != 8'h00) && (in_tdata == ";")) begin
      emit_node = ND_IDLE;
      emit_tail = 1'b1;
      node_nxt  = ND_IDLE;
    end else if (step.hit) begin
      // A prefix cut short by the end of the string goes out literally.
      emit_node = in_tlast ? step.next : ND_IDLE;
      node_nxt  = step.next;
    end else begin
      emit_node = node_r;
      if ((in_tdata == "&") && !in_tlast) begin
        node_nxt = ND_AMP;
      end else begin
        emit_tail = 1'b1;
        node_nxt  = ND_IDLE;
      end
    end
    if (in_tlast) begin
      node_nxt = ND_IDLE;
    end

    held     = held_text(emit_node);
    emit_len = held_len(emit_node);
    emit_cnt = emit_len + cnt_t'(emit_tail);
    for (int i = 0; i < OUT_DEPTH; i++) begin
      if (cnt_t'(i) < emit_len) begin
        lst[i] = held[8*i +: 8];
      end else if ((ent != 8'h00) && (in_tdata == ";")) begin
        lst[i] = ent;
      end else begin
        lst[i] = in_tdata;
      end
    end
  end

  // Output buffer: shift on a taken byte, reload on an accepted word.
  always_comb begin
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    for (int i = 0; i < OUT_DEPTH; i++) begin
      buf_nxt[i] = buf_r[i];
    end
    if (out_fire) begin
      cnt_nxt = cnt_r - cnt_t'(1);
      for (int i = 0; i < OUT_DEPTH - 1; i++) begin
        buf_nxt[i] = buf_r[i + 1];
      end
    end
    if (in_fire) begin
      cnt_nxt  = emit_cnt;
      last_nxt = in_tlast;
      for (int i = 0; i < OUT_DEPTH; i++) begin
        buf_nxt[i] = lst[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r <= ND_IDLE;
      cnt_r  <= '0;
      last_r <= 1'b0;
    end else begin
      if (in_fire) begin
        node_r <= node_nxt;
      end
      cnt_r  <= cnt_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < OUT_DEPTH; i++) begin
      buf_r[i] <= buf_nxt[i];
    end
  end

  // The buffer never holds more than the longest burst.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(OUT_DEPTH))
    else $error("output buffer count out of range");

  // The end of a string always leaves the trie empty and produces output.
  a_eos_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> (node_r == ND_IDLE) && out_tvalid && last_r)
    else $error("end of string did not flush");

  // A stalled byte stays put, as a word is only taken once the previous burst is fully delivered.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast && !out_tready) |=> $stable(out_tdata))
    else $error("buffered byte overwritten before delivery");

endmodule

// ===== tb/sv/xml_entity_unescape_unit_tb.sv =====
// ----------------------------------------------------------------------------
// xml_entity_unescape_unit_tb: self-checking bench of the entity decoder
// Drives escaped strings one byte per word into the block and checks every
// output word against a trie-based decoder held in the bench. A directed
// table covers the extremes and the end-of-string cases. Random strings of
// entities, broken prefixes and noise then run under changing back-pressure.
// ----------------------------------------------------------------------------
module xml_entity_unescape_unit_tb;
  import xeu_pkg::*;

  typedef struct packed {
    logic [7:0] plain;
    logic       last;
  } plain_word_t;

  typedef struct packed {
    logic [7:0] text;
    logic       eos;
  } text_word_t;

  typedef struct packed {
    logic        lit;
    plain_word_t want;
  } word_tag_t;

  typedef struct packed {
    logic [7:0] text;
    logic       eos;
    logic       lit;
    logic [7:0] want;
    logic       want_last;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 26;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;

  // Bytes held at each trie node, indexed by the node code.
  string held_str [16] = '{"", "&", "&l", "&lt", "&g", "&gt", "&q", "&qu", "&quo",
                           "&quot", "&a", "&ap", "&apo", "&apos", "&am", "&amp"};
  logic [7:0] entity_chr [16] = '{8'h00, 8'h00, 8'h00, "<", 8'h00, ">", 8'h00,
                                  8'h00, 8'h00, "\"", 8'h00, 8'h00, 8'h00, "'",
                                  8'h00, "&"};
  string ent_name [5] = '{"&lt;", "&gt;", "&quot;", "&apos;", "&amp;"};

  // Rows with lit set carry their single expected word; the rest use the decoder.
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{8'h00, 1'b1, 1'b1, 8'h00, 1'b1},
    '{8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1},
    '{"&",   1'b1, 1'b1, "&",   1'b1},
    '{"&",   1'b0, 1'b0, 8'h00, 1'b0},
    '{"l",   1'b0, 1'b0, 8'h00, 1'b0},
    '{"t",   1'b0, 1'b0, 8'h00, 1'b0},
    '{";",   1'b1, 1'b1, "<",   1'b1},
    '{"&",   1'b0, 1'b0, 8'h00, 1'b0},
    '{"q",   1'b0, 1'b0, 8'h00, 1'b0},
    '{"u",   1'b1, 1'b0, 8'h00, 1'b0},
    '{"&",   1'b0, 1'b0, 8'h00, 1'b0},
    '{"#",   1'b0, 1'b0, 8'h00, 1'b0},
    '{";",   1'b0, 1'b1, ";",   1'b0},
    '{"x",   1'b1, 1'b1, "x",   1'b1},
    '{"&",   1'b0, 1'b0, 8'h00, 1'b0},
    '{"&",   1'b0, 1'b0, 8'h00, 1'b0},
    '{"a",   1'b0, 1'b0, 8'h00, 1'b0},
    '{"m",   1'b0, 1'b0, 8'h00, 1'b0},
    '{"p",   1'b0, 1'b0, 8'h00, 1'b0},
    '{";",   1'b1, 1'b1, "&",   1'b1},
    '{"&",   1'b0, 1'b0, 8'h00, 1'b0},
    '{"a",   1'b0, 1'b0, 8'h00, 1'b0},
    '{"p",   1'b0, 1'b0, 8'h00, 1'b0},
    '{"o",   1'b0, 1'b0, 8'h00, 1'b0},
    '{"s",   1'b0, 1'b0, 8'h00, 1'b0},
    '{"!",   1'b1, 1'b0, 8'h00, 1'b0}
  };

  node_t       prefix_node;
  plain_word_t plain_q [$];
  word_tag_t   offered_q [$];
  text_word_t  stim_q [$];
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned hold_left;
  int unsigned bad_words;

  xml_entity_unescape_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] text_byte
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [7:0] plain_byte
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic release_held(input node_t n);
    int unsigned i;
    for (i = 0; i < held_str[n].len(); i++) begin
      plain_q.push_back('{held_str[n].getc(i), 1'b0});
    end
  endtask

  // Decodes one accepted word and queues the plain words it yields.
  task automatic decode_word(input logic [7:0] b, input logic eos);
    int unsigned k, j, ln, first;
    int          nx;
    logic        same;
    node_t       n;
    n     = prefix_node;
    first = plain_q.size();
    ln    = held_str[n].len();
    nx    = -1;
    // The next node is the one whose held text is the current text plus b.
    for (k = 1; k < 16; k++) begin
      if (held_str[k].len() == ln + 1 && held_str[k].getc(ln) == b) begin
        same = 1'b1;
        for (j = 0; j < ln; j++) begin
          if (held_str[k].getc(j) != held_str[n].getc(j)) same = 1'b0;
        end
        if (same) nx = k;
      end
    end
    if (entity_chr[n] != 8'h00 && b == ";") begin
      plain_q.push_back('{entity_chr[n], 1'b0});
      n = ND_IDLE;
    end else if (nx >= 0) begin
      n = node_t'(nx);
      if (eos) begin
        release_held(n);
        n = ND_IDLE;
      end
    end else begin
      release_held(n);
      if (b == "&" && !eos) begin
        n = ND_AMP;
      end else begin
        plain_q.push_back('{b, 1'b0});
        n = ND_IDLE;
      end
    end
    if (eos) begin
      if (plain_q.size() > first) plain_q[plain_q.size()-1].last = 1'b1;
      n = ND_IDLE;
    end
    prefix_node = n;
  endtask

  function automatic void flag_mismatch(input string what, input int want, input int got);
    bad_words++;
    if (bad_words <= 10) begin
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    end
  endfunction

  // One random string built from entities, broken prefixes and noise bytes.
  task automatic build_string();
    int unsigned tokens, t, kind, e, ln, i;
    string       s;
    logic [7:0]  c;
    text_word_t  w;
    tokens = $urandom_range(1, 10);
    for (t = 0; t < tokens; t++) begin
      kind = $urandom_range(0, 99);
      e    = $urandom_range(0, 4);
      s    = ent_name[e];
      if (kind < 35) ln = s.len();
      else if (kind < 55) ln = $urandom_range(1, s.len() - 1);
      else ln = 0;
      for (i = 0; i < ln; i++) begin
        c = s.getc(i);
        // Flipping the case gives unknown names such as &LT; that must pass.
        if (kind >= 35 && kind < 55 && i > 0 && $urandom_range(0, 3) == 0) c = c ^ 8'h20;
        stim_q.push_back('{c, 1'b0});
      end
      if (kind >= 45 && kind < 55) stim_q.push_back('{";", 1'b0});
      else if (kind >= 55 && kind < 62) stim_q.push_back('{"&", 1'b0});
      else if (kind >= 62) stim_q.push_back('{8'($urandom_range(0, 255)), 1'b0});
    end
    w     = stim_q.pop_back();
    w.eos = 1'b1;
    stim_q.push_back(w);
  endtask

  task automatic send_word(input logic [7:0] b, input logic eos, input word_tag_t tag);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    offered_q.push_back(tag);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  always @(posedge clk) begin : accept_mon
    word_tag_t   tag;
    int unsigned depth;
    if (rst_n && in_tvalid && in_tready) begin
      tag   = offered_q.pop_front();
      depth = plain_q.size();
      decode_word(in_tdata, in_tlast);
      if (tag.lit) begin
        while (plain_q.size() > depth) void'(plain_q.pop_back());
        plain_q.push_back(tag.want);
      end
    end
  end

  always @(posedge clk) begin : result_mon
    plain_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (plain_q.size() == 0) begin
        flag_mismatch("unexpected word", 0, {out_tlast, out_tdata});
      end else begin
        want = plain_q.pop_front();
        if (out_tdata !== want.plain) flag_mismatch("plain_byte", want.plain, out_tdata);
        if (out_tlast !== want.last) flag_mismatch("last_byte", want.last, out_tlast);
      end
    end
  end

  // Receiver: random stalls, or a long counted hold-off when one is requested.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[xml_entity_unescape_unit] ERROR");
    $finish;
  end

  initial begin
    int unsigned i, n;
    word_tag_t   tag;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= 8'h00;
    in_tlast    <= 1'b0;
    prefix_node = ND_IDLE;
    bad_words   = 0;
    hold_left   = 0;
    tx_idle_pct = 9;
    rx_idle_pct = 72;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++) begin
      tag.lit  = directed_rows[i].lit;
      tag.want = '{directed_rows[i].want, directed_rows[i].want_last};
      send_word(directed_rows[i].text, directed_rows[i].eos, tag);
    end

    while (stim_q.size() < 320) build_string();
    n   = stim_q.size();
    tag = '0;
    for (i = 0; i < n; i++) begin
      if (i == n / 3) begin
        tx_idle_pct = 72;
        rx_idle_pct = 9;
      end else if (i == 2 * n / 3) begin
        // The sender keeps offering while the output is held, so the
        // buffer fills and the input stalls.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_left   = 80;
      end
      send_word(stim_q[i].text, stim_q[i].eos, tag);
    end
    in_tvalid <= 1'b0;

    while (plain_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (bad_words == 0 && plain_q.size() == 0) begin
      $display("[xml_entity_unescape_unit] OK");
    end else begin
      $display("[xml_entity_unescape_unit] ERROR");
    end
    $finish;
  end

endmodule
